// ----- hdl/ata_pio_lba28_disk_device_top_assert.svh -----
// Assertion macros for the ATA PIO LBA28 disk device.
`ifndef ATA_PIO_LBA28_DISK_DEVICE_TOP_ASSERT_SVH
`define ATA_PIO_LBA28_DISK_DEVICE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define ATAD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check an implication whose consequent is due in the cycle after its trigger.
`define ATAD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define ATAD_ASSERT(lbl, prop, msg)
`define ATAD_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

// ----- hdl/atad_pkg.sv -----
// Shared types and constants of the ATA PIO LBA28 disk device.
`timescale 1ns / 1ps
package atad_pkg;

	localparam int DISK_SECTORS_DEF = 64;
	localparam int WORDS_PER_SECTOR = 256;
	localparam int WORD_IDX_W       = 8;
	localparam int LBA_W            = 28;
	localparam int SECT_LEFT_W      = 9;
	localparam int DATA_W           = 16;

	localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
	localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
	localparam logic [7:0] STATUS_DRDY       = 8'h40;
	localparam logic [7:0] STATUS_DRQ        = 8'h08;
	localparam logic [7:0] STATUS_ERR        = 8'h01;
	localparam logic [7:0] ERR_ABRT          = 8'h04;
	localparam logic [7:0] DRIVE_HEAD_RESET  = 8'hE0;
	localparam logic [7:0] COUNT_RESET       = 8'h01;

	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} acc_t;

	typedef enum logic [2:0] {
		OFF_DATA   = 3'd0,
		OFF_ERROR  = 3'd1,
		OFF_COUNT  = 3'd2,
		OFF_LBA0   = 3'd3,
		OFF_LBA1   = 3'd4,
		OFF_LBA2   = 3'd5,
		OFF_DRIVE  = 3'd6,
		OFF_STATUS = 3'd7
	} reg_off_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctl_t;

	typedef struct packed {
		logic              from_mem;
		logic [DATA_W-1:0] reg_data;
	} rd_sel_t;

endpackage

// ----- hdl/atad_if.sv -----
// Valid/ready channel interfaces for bus accesses and read results.
`timescale 1ns / 1ps
interface atad_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [2:0]  reg_offset;
	logic [15:0] write_data;

	modport source (output valid, output command, output reg_offset, output write_data,
		input ready);
	modport sink (input valid, input command, input reg_offset, input write_data,
		output ready);
endinterface

interface atad_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

// ----- hdl/atad_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module atad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             rd_en,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end
endmodule

// ----- hdl/atad_taskfile.sv -----
// Task file registers, transfer sequencer and store access decode.
`timescale 1ns / 1ps
module atad_taskfile #(
	parameter int DISK_SECTORS = atad_pkg::DISK_SECTORS_DEF,
	parameter int AW           = $clog2(DISK_SECTORS * atad_pkg::WORDS_PER_SECTOR)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc,
	input  logic                     command,
	input  logic [2:0]               reg_offset,
	input  logic [15:0]              write_data,
	output atad_pkg::ram_ctl_t       ram_ctl,
	output logic [AW-1:0]            ram_addr,
	output atad_pkg::rd_sel_t        rd_sel
);
	import atad_pkg::*;

	localparam logic [LBA_W-1:0] LBA_LIMIT = LBA_W'(DISK_SECTORS);
	localparam int FULL_W = LBA_W + WORD_IDX_W;

	logic [7:0]             count_q, lba0_q, lba1_q, lba2_q, drive_q, error_q;
	logic [7:0]             count_d, lba0_d, lba1_d, lba2_d, drive_d, error_d;
	mode_t                  mode_q, mode_d;
	logic [WORD_IDX_W-1:0]  widx_q, widx_d;
	logic [SECT_LEFT_W-1:0] sleft_q, sleft_d;
	logic [LBA_W-1:0]       lba_q, lba_d;
	logic                   err_flag_q, err_flag_d;

	acc_t                   acc_kind;
	reg_off_t               off;
	logic [7:0]             wbyte;
	logic                   data_rd, data_wr;
	logic [LBA_W-1:0]       start_lba, lba_inc;
	logic [SECT_LEFT_W-1:0] sleft_dec;
	logic [FULL_W-1:0]      full_addr;
	logic [7:0]             status;

	assign acc_kind  = acc_t'(command);
	assign off       = reg_off_t'(reg_offset);
	assign wbyte     = write_data[7:0];
	assign data_rd   = acc && acc_kind == ACC_READ && off == OFF_DATA && mode_q == MODE_READ;
	assign data_wr   = acc && acc_kind == ACC_WRITE && off == OFF_DATA && mode_q == MODE_WRITE;
	assign start_lba = {drive_q[3:0], lba2_q, lba1_q, lba0_q};
	assign lba_inc   = lba_q + LBA_W'(1);
	assign sleft_dec = (sleft_q != '0) ? sleft_q - SECT_LEFT_W'(1) : '0;
	assign full_addr = {lba_q, widx_q};

	// Next state
	always_comb begin
		count_d    = count_q;
		lba0_d     = lba0_q;
		lba1_d     = lba1_q;
		lba2_d     = lba2_q;
		drive_d    = drive_q;
		error_d    = error_q;
		mode_d     = mode_q;
		widx_d     = widx_q;
		sleft_d    = sleft_q;
		lba_d      = lba_q;
		err_flag_d = err_flag_q;
		if (data_rd || data_wr) begin
			widx_d = widx_q + WORD_IDX_W'(1);
			if (widx_q == '1) begin
				lba_d   = lba_inc;
				sleft_d = sleft_dec;
				if (sleft_dec == '0) begin
					mode_d = MODE_IDLE;
				end else if (lba_inc >= LBA_LIMIT) begin
					error_d    = ERR_ABRT;
					err_flag_d = 1'b1;
					mode_d     = MODE_IDLE;
					widx_d     = '0;
					sleft_d    = '0;
				end
			end
		end else if (acc && acc_kind == ACC_WRITE) begin
			unique case (off)
				OFF_COUNT: count_d = wbyte;
				OFF_LBA0:  lba0_d  = wbyte;
				OFF_LBA1:  lba1_d  = wbyte;
				OFF_LBA2:  lba2_d  = wbyte;
				OFF_DRIVE: drive_d = wbyte;
				OFF_STATUS: begin
					if ((wbyte != CMD_READ_SECTORS && wbyte != CMD_WRITE_SECTORS)
							|| start_lba >= LBA_LIMIT) begin
						error_d    = ERR_ABRT;
						err_flag_d = 1'b1;
						mode_d     = MODE_IDLE;
						widx_d     = '0;
						sleft_d    = '0;
					end else begin
						error_d    = '0;
						err_flag_d = 1'b0;
						lba_d      = start_lba;
						widx_d     = '0;
						sleft_d    = {count_q == '0, count_q};
						mode_d     = (wbyte == CMD_READ_SECTORS) ? MODE_READ : MODE_WRITE;
					end
				end
				default: ;
			endcase
		end
	end

	// Outputs
	always_comb begin
		status          = STATUS_DRDY | ((mode_q != MODE_IDLE) ? STATUS_DRQ : 8'h00)
			| (err_flag_q ? STATUS_ERR : 8'h00);
		ram_ctl.rd_en   = data_rd;
		ram_ctl.wr_en   = data_wr;
		ram_addr        = full_addr[AW-1:0];
		rd_sel.from_mem = data_rd;
		rd_sel.reg_data = '0;
		if (acc_kind == ACC_READ) begin
			unique case (off)
				OFF_DATA:   rd_sel.reg_data = '0;
				OFF_ERROR:  rd_sel.reg_data = {8'h00, error_q};
				OFF_COUNT:  rd_sel.reg_data = {8'h00, count_q};
				OFF_LBA0:   rd_sel.reg_data = {8'h00, lba0_q};
				OFF_LBA1:   rd_sel.reg_data = {8'h00, lba1_q};
				OFF_LBA2:   rd_sel.reg_data = {8'h00, lba2_q};
				OFF_DRIVE:  rd_sel.reg_data = {8'h00, drive_q};
				OFF_STATUS: rd_sel.reg_data = {8'h00, status};
				default:    rd_sel.reg_data = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= COUNT_RESET;
			lba0_q     <= '0;
			lba1_q     <= '0;
			lba2_q     <= '0;
			drive_q    <= DRIVE_HEAD_RESET;
			error_q    <= '0;
			mode_q     <= MODE_IDLE;
			widx_q     <= '0;
			sleft_q    <= '0;
			lba_q      <= '0;
			err_flag_q <= 1'b0;
		end else begin
			count_q    <= count_d;
			lba0_q     <= lba0_d;
			lba1_q     <= lba1_d;
			lba2_q     <= lba2_d;
			drive_q    <= drive_d;
			error_q    <= error_d;
			mode_q     <= mode_d;
			widx_q     <= widx_d;
			sleft_q    <= sleft_d;
			lba_q      <= lba_d;
			err_flag_q <= err_flag_d;
		end
	end
endmodule

// ----- hdl/ata_pio_lba28_disk_device_top.sv -----
// Top level of the ATA PIO LBA28 disk device.
`timescale 1ns / 1ps
// Disk-side ATA task file with READ SECTORS / WRITE SECTORS over PIO. Every req
// transaction is one bus access to one of the eight command block registers and
// yields exactly one rsp transaction carrying read_data (zero for writes). The
// block takes one transaction per clock while rsp is not stalled and delivers
// its result in the next cycle, matching the registered read port of the sector
// store RAM. A stalled rsp holds req.ready low, so up to one result is in flight.
// The sector store holds DISK_SECTORS * 256 words, is not cleared by reset and
// needs no start-up pass: reading a word that was never written returns junk.
module ata_pio_lba28_disk_device_top #(
	parameter int DISK_SECTORS = atad_pkg::DISK_SECTORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	atad_req_if.sink   req,
	atad_rsp_if.source rsp
);
	import atad_pkg::*;

	localparam int STORE_WORDS = DISK_SECTORS * WORDS_PER_SECTOR;
	localparam int AW          = $clog2(STORE_WORDS);

	logic              acc;
	ram_ctl_t          ram_ctl;
	logic [AW-1:0]     ram_addr;
	logic [DATA_W-1:0] ram_rdata;
	rd_sel_t           rd_sel;

	logic              valid_s1;
	logic              from_mem_s1;
	logic [DATA_W-1:0] reg_data_s1;

	// Accept whenever the result slot is empty or drains this cycle.
	assign req.ready = !valid_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;

	atad_taskfile #(
		.DISK_SECTORS (DISK_SECTORS),
		.AW           (AW)
	) u_taskfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.command    (req.command),
		.reg_offset (req.reg_offset),
		.write_data (req.write_data),
		.ram_ctl    (ram_ctl),
		.ram_addr   (ram_addr),
		.rd_sel     (rd_sel)
	);

	// Read data stays put while rsp stalls: no new read is issued until the slot frees.
	atad_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_WORDS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_ctl.wr_en),
		.rd_en   (ram_ctl.rd_en),
		.addr    (ram_addr),
		.wr_data (req.write_data),
		.rd_data (ram_rdata)
	);

	// Result stage: hold register reads here, pick the RAM word for data reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			from_mem_s1 <= rd_sel.from_mem;
			reg_data_s1 <= rd_sel.reg_data;
		end
	end

	assign rsp.valid     = valid_s1;
	assign rsp.read_data = from_mem_s1 ? ram_rdata : reg_data_s1;

	// Assertions
	logic acc_wr, acc_status_rd, status_ok;
	assign acc_wr        = acc && req.command == ACC_WRITE;
	assign acc_status_rd = acc && req.command == ACC_READ && req.reg_offset == OFF_STATUS;
	// Status shape: BSY clear, DRDY set, bit 5 clear, upper byte zero.
	assign status_ok     = rsp.read_data[15:7] == '0 && rsp.read_data[6] && !rsp.read_data[5];

`include "ata_pio_lba28_disk_device_top_assert.svh"

	`ATAD_ASSERT_NEXT(a_one_cycle_result, acc, rsp.valid, "accepted access gave no result")
	`ATAD_ASSERT_NEXT(a_write_reads_zero, acc_wr, rsp.read_data == '0, "write result not zero")
	`ATAD_ASSERT_NEXT(a_status_shape, acc_status_rd, status_ok, "status shows BSY or lacks DRDY")
endmodule

// ----- verif/tb.sv -----
// Testbench for the ATA PIO LBA28 disk device: task file accesses checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import atad_pkg::*;

	localparam int DISK_SECTORS = DISK_SECTORS_DEF;
	localparam int STORE_WORDS  = DISK_SECTORS * WORDS_PER_SECTOR;
	localparam int ITEMS_TOTAL  = 550;     // counted accesses before the stimulus stops
	localparam int PHASE_LEN    = 64;      // accesses per idling phase
	localparam int HOLD_CYCLES  = 60;      // long receiver hold-off
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		acc_t              acc;
		reg_off_t          off;
		logic [DATA_W-1:0] data;
	} access_t;

	logic clk;
	logic arst_n;

	atad_req_if acc_bus ();
	atad_rsp_if rd_bus ();

	ata_pio_lba28_disk_device_top #(
		.DISK_SECTORS(DISK_SECTORS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (acc_bus),
		.rsp   (rd_bus)
	);

	// Accesses waiting for the driver, and read data owed by the block.
	access_t           pending_accesses[$];
	logic [DATA_W-1:0] expected_read_data[$];

	int  n_issued;        // accesses handed to the driver
	int  n_accepted;      // accesses taken by the block
	int  n_counted;       // accesses that do something, for the stop condition
	int  n_errors;
	int  src_idle_pct;
	int  snk_stall_pct;
	int  hold_asks;       // bumped by the stimulus to request a long hold-off
	int  hold_seen;
	int  hold_left;       // owned by the receiver process
	int  cycles;
	bit  req_fired;       // handshake seen at the last rising edge

	// Predicted task file and transfer state, reset values as after arst_n.
	logic [7:0]        tf_count  = COUNT_RESET;
	logic [7:0]        tf_lba[3] = '{default: 8'h00};
	logic [7:0]        tf_drive  = DRIVE_HEAD_RESET;
	logic [7:0]        tf_error  = 8'h00;
	mode_t             xfer_mode = MODE_IDLE;
	logic [7:0]        xfer_word = 8'h00;
	logic [8:0]        xfer_left = 9'd0;
	logic [LBA_W-1:0]  xfer_lba  = '0;
	bit                err_flag  = 1'b0;
	logic [DATA_W-1:0] disk_words[STORE_WORDS];
	bit                disk_written[STORE_WORDS];

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Store word addressed by the open transfer; out of range folds to 0.
	function automatic int unsigned disk_addr();
		int unsigned a;
		a = int'(xfer_lba) * WORDS_PER_SECTOR + int'(xfer_word);
		return a < STORE_WORDS ? a : 0;
	endfunction

	// Abort: flag ABRT and close any open transfer.
	function automatic void abort_xfer();
		tf_error  = ERR_ABRT;
		err_flag  = 1'b1;
		xfer_mode = MODE_IDLE;
		xfer_word = 8'h00;
		xfer_left = 9'd0;
	endfunction

	// Advance one data word; at a sector boundary move on to the next LBA,
	// close the transfer when the count runs out, abort past the disk end.
	function automatic void next_word();
		xfer_word = xfer_word + 8'd1;
		if (xfer_word == 8'h00) begin
			xfer_lba = xfer_lba + 1'b1;
			if (xfer_left != 0)
				xfer_left = xfer_left - 1'b1;
			if (xfer_left == 0)
				xfer_mode = MODE_IDLE;
			else if (xfer_lba >= DISK_SECTORS)
				abort_xfer();
		end
	endfunction

	// Apply one bus access to the predicted state and return its read data.
	function automatic logic [DATA_W-1:0] task_file_access(acc_t acc, reg_off_t off,
		logic [DATA_W-1:0] wd);
		logic [7:0]       b;
		logic [DATA_W-1:0] rd;
		logic [LBA_W-1:0] start;
		b  = wd[7:0];
		rd = '0;
		if (acc == ACC_WRITE) begin
			case (off)
				OFF_DATA: begin
					// Data writes land only while a write transfer is open.
					if (xfer_mode == MODE_WRITE) begin
						disk_words[disk_addr()]   = wd;
						disk_written[disk_addr()] = 1'b1;
						next_word();
					end
				end
				OFF_COUNT: tf_count  = b;
				OFF_LBA0:  tf_lba[0] = b;
				OFF_LBA1:  tf_lba[1] = b;
				OFF_LBA2:  tf_lba[2] = b;
				OFF_DRIVE: tf_drive  = b;
				OFF_STATUS: begin
					start = {tf_drive[3:0], tf_lba[2], tf_lba[1], tf_lba[0]};
					if ((b != CMD_READ_SECTORS && b != CMD_WRITE_SECTORS) ||
						start >= DISK_SECTORS) begin
						abort_xfer();
					end else begin
						// A good command replaces whatever transfer is open.
						tf_error  = 8'h00;
						err_flag  = 1'b0;
						xfer_lba  = start;
						xfer_word = 8'h00;
						xfer_left = (tf_count == 8'h00) ? 9'd256 : {1'b0, tf_count};
						xfer_mode = (b == CMD_READ_SECTORS) ? MODE_READ : MODE_WRITE;
					end
				end
				default: ;  // error register is read-only
			endcase
		end else begin
			case (off)
				OFF_DATA: begin
					if (xfer_mode == MODE_READ) begin
						rd = disk_words[disk_addr()];
						next_word();
					end
				end
				OFF_ERROR: rd = {8'h00, tf_error};
				OFF_COUNT: rd = {8'h00, tf_count};
				OFF_LBA0:  rd = {8'h00, tf_lba[0]};
				OFF_LBA1:  rd = {8'h00, tf_lba[1]};
				OFF_LBA2:  rd = {8'h00, tf_lba[2]};
				OFF_DRIVE: rd = {8'h00, tf_drive};
				default: begin
					rd = {8'h00, STATUS_DRDY |
						(xfer_mode != MODE_IDLE ? STATUS_DRQ : 8'h00) |
						(err_flag ? STATUS_ERR : 8'h00)};
				end
			endcase
		end
		return rd;
	endfunction

	// A data read is allowed unless it would fetch a store word never written.
	function automatic bit data_read_safe();
		return xfer_mode != MODE_READ || disk_written[disk_addr()];
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset, watchdog
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drive every input to a known value at time zero; hold reset, then release it at a falling edge.
	initial begin
		arst_n             = 1'b0;
		acc_bus.valid      = 1'b0;
		acc_bus.command    = 1'b0;
		acc_bus.reg_offset = 3'd0;
		acc_bus.write_data = 16'h0000;
		rd_bus.ready       = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Bound the run; a hang anywhere ends up here.
	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: present queued accesses at the falling edge, idling at random
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		access_t nxt;
		if (!arst_n) begin
			acc_bus.valid <= 1'b0;
		end else if (!acc_bus.valid || req_fired) begin
			if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				nxt = pending_accesses.pop_front();
				acc_bus.valid      <= 1'b1;
				acc_bus.command    <= nxt.acc;
				acc_bus.reg_offset <= nxt.off;
				acc_bus.write_data <= nxt.data;
			end else begin
				acc_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request.
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rd_bus.ready <= 1'b0;
		end else begin
			rd_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted access, check each read transaction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		req_fired = arst_n && acc_bus.valid && acc_bus.ready;
		if (req_fired) begin
			expected_read_data.push_back(task_file_access(acc_t'(acc_bus.command),
				reg_off_t'(acc_bus.reg_offset), acc_bus.write_data));
			n_accepted++;
		end
		if (arst_n && rd_bus.valid && rd_bus.ready) begin
			if (expected_read_data.size() == 0) begin
				$error("read_data: expected nothing, got %h", rd_bus.read_data);
				n_errors++;
			end else begin
				want = expected_read_data.pop_front();
				if (rd_bus.read_data !== want) begin
					$error("read_data: expected %h, got %h", want, rd_bus.read_data);
					n_errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Wait until the predictor has seen every access handed out so far.
	task automatic settle();
		while (n_accepted != n_issued) begin
			@(posedge clk);
			#1;
		end
	endtask

	// Hand one access to the driver. Accesses go out one at a time so the
	// predicted state is current when the next one is chosen; that keeps
	// data reads away from store words that were never written.
	task automatic issue(acc_t acc, reg_off_t off, logic [DATA_W-1:0] wd);
		access_t a;
		settle();
		if (acc == ACC_READ && off == OFF_DATA && !data_read_safe())
			off = OFF_STATUS;
		if (!(acc == ACC_WRITE &&
			(off == OFF_ERROR || (off == OFF_DATA && xfer_mode != MODE_WRITE))))
			n_counted++;
		// Rotate idling so gaps hit every stage of a transfer.
		case ((n_issued / PHASE_LEN) % 4)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
			default: begin src_idle_pct = 24; snk_stall_pct = 24; end
		endcase
		// Long receiver hold-off while this access is offered: the block fills
		// and drops ready on its input.
		if (n_issued % 200 == 100)
			hold_asks++;
		// Pause the sender until every result is back.
		if (n_issued % 200 == 199) begin
			while (expected_read_data.size() != 0) begin
				@(posedge clk);
				#1;
			end
		end
		a.acc  = acc;
		a.off  = off;
		a.data = wd;
		pending_accesses.push_back(a);
		n_issued++;
	endtask

	// Load count, LBA and drive/head; upper data bytes carry junk.
	task automatic load_task_file(logic [LBA_W-1:0] lba, logic [7:0] count);
		issue(ACC_WRITE, OFF_COUNT, {8'($urandom), count});
		issue(ACC_WRITE, OFF_LBA0, {8'($urandom), lba[7:0]});
		issue(ACC_WRITE, OFF_LBA1, {8'($urandom), lba[15:8]});
		issue(ACC_WRITE, OFF_LBA2, {8'($urandom), lba[23:16]});
		issue(ACC_WRITE, OFF_DRIVE, {8'($urandom), 4'($urandom), lba[27:24]});
	endtask

	initial begin
		logic [LBA_W-1:0]  lba;
		logic [LBA_W-1:0]  last_wr_lba;
		logic [7:0]        count;
		logic [DATA_W-1:0] wd;
		acc_t              acc;
		reg_off_t          off;
		bit                have_wr;
		int                len;
		int                kind;
		int                ep;

		have_wr     = 1'b0;
		last_wr_lba = '0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		#1;

		// Directed: reset values, ignored accesses, aborts, a short transfer.
		issue(ACC_READ, OFF_STATUS, 16'h0000);
		issue(ACC_READ, OFF_ERROR, 16'hFFFF);
		issue(ACC_READ, OFF_COUNT, 16'h0000);
		issue(ACC_READ, OFF_LBA0, 16'h0000);
		issue(ACC_READ, OFF_LBA1, 16'h0000);
		issue(ACC_READ, OFF_LBA2, 16'h0000);
		issue(ACC_READ, OFF_DRIVE, 16'h0000);
		issue(ACC_READ, OFF_DATA, 16'h0000);                      // no read open
		issue(ACC_WRITE, OFF_DATA, 16'hFFFF);                     // no write open
		issue(ACC_WRITE, OFF_ERROR, 16'hFFFF);                    // read-only register
		issue(ACC_WRITE, OFF_STATUS, 16'hFFFF);                   // unknown command
		issue(ACC_READ, OFF_ERROR, 16'h0000);
		issue(ACC_READ, OFF_STATUS, 16'h0000);
		issue(ACC_WRITE, OFF_LBA0, 16'hFFFF);
		issue(ACC_WRITE, OFF_STATUS, {8'hFF, CMD_READ_SECTORS});  // start LBA past the end
		issue(ACC_WRITE, OFF_LBA0, 16'hFF00);
		issue(ACC_WRITE, OFF_COUNT, 16'h0000);                    // count 0 means 256
		issue(ACC_WRITE, OFF_STATUS, {8'h00, CMD_WRITE_SECTORS});
		issue(ACC_WRITE, OFF_DATA, 16'hFFFF);
		issue(ACC_READ, OFF_DATA, 16'h0000);                      // read during a write
		issue(ACC_WRITE, OFF_DATA, 16'h0000);
		issue(ACC_WRITE, OFF_STATUS, {8'hA5, CMD_READ_SECTORS});  // replaces the write
		issue(ACC_WRITE, OFF_DATA, 16'h1234);                     // write during a read
		issue(ACC_READ, OFF_DATA, 16'h0000);
		issue(ACC_READ, OFF_DATA, 16'h0000);
		issue(ACC_WRITE, OFF_DRIVE, 16'h00EF);                    // drive/head stored whole
		issue(ACC_WRITE, OFF_STATUS, {8'h00, CMD_WRITE_SECTORS}); // LBA high nibble set

		// Random: mostly well-formed transfers with random content, some noise.
		// The first episode writes across a sector boundary near the disk end,
		// the second reads a long run of it back.
		ep = 0;
		while (n_counted < ITEMS_TOTAL) begin
			kind = (ep == 0) ? 0 : (ep == 1) ? 4 : $urandom_range(0, 9);
			if (kind < 4) begin
				if (ep == 0) begin
					lba = LBA_W'(DISK_SECTORS - 2 + $urandom_range(0, 1));
				end else begin
					case ($urandom_range(0, 3))
						0: lba = LBA_W'(DISK_SECTORS - 1);
						1: lba = LBA_W'($urandom_range(0, 3));
						2: lba = LBA_W'($urandom);
						default: lba = LBA_W'($urandom_range(0, DISK_SECTORS - 1));
					endcase
				end
				count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
				load_task_file(lba, count);
				issue(ACC_WRITE, OFF_STATUS, {8'($urandom), CMD_WRITE_SECTORS});
				len = (ep == 0) ? WORDS_PER_SECTOR + $urandom_range(1, 12) : $urandom_range(1, 24);
				repeat (len) begin
					if ($urandom_range(0, 9) == 0)
						issue(ACC_READ, reg_off_t'(3'($urandom)), 16'($urandom));
					issue(ACC_WRITE, OFF_DATA, 16'($urandom));
				end
				if (lba < DISK_SECTORS) begin
					have_wr     = 1'b1;
					last_wr_lba = lba;
				end
			end else if (kind < 8 && have_wr) begin
				load_task_file(last_wr_lba, 8'($urandom_range(0, 3)));
				issue(ACC_WRITE, OFF_STATUS, {8'($urandom), CMD_READ_SECTORS});
				settle();
				len = (ep == 1) ? $urandom_range(16, 270) : $urandom_range(1, 32);
				// Stop at the first word that was never written.
				while (len > 0 && data_read_safe()) begin
					if ($urandom_range(0, 9) == 0)
						issue(acc_t'(1'($urandom)), reg_off_t'($urandom_range(1, 6)),
							16'($urandom));
					issue(ACC_READ, OFF_DATA, 16'($urandom));
					settle();
					len--;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					acc = acc_t'(1'($urandom));
					off = reg_off_t'(3'($urandom));
					wd  = 16'($urandom);
					if (acc == ACC_WRITE && off == OFF_STATUS && $urandom_range(0, 1) == 1)
						wd[7:0] = ($urandom_range(0, 1) == 1) ? CMD_READ_SECTORS
							: CMD_WRITE_SECTORS;
					issue(acc, off, wd);
				end
			end
			ep++;
		end

		// Drain: wait until every access is taken and every result is back, then finish.
		settle();
		while (expected_read_data.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (8) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
